// ----- rtl/core/izh_pkg.sv -----
// Types, constants and saturating helpers shared by the neuron core and its multiplier.
package izh_pkg;

	localparam int FRAC_BITS = 24;
	localparam int STATE_WIDTH = 48;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int MS_W = 16;
	localparam int MS_PER_S = 1000;
	localparam int MS_HALF = MS_PER_S / 2;
	localparam int DIV_W = MS_W + FRAC_BITS;
	localparam int MS_FX_INT = (1 << FRAC_BITS) / MS_PER_S;
	localparam int MS_FX_REM = (1 << FRAC_BITS) % MS_PER_S;
	localparam int REM_W = $clog2(MS_FX_REM * ((1 << MS_W) - 1) + MS_HALF + 1);
	localparam int RECIP_SH = 34;
	localparam int RECIP_W = RECIP_SH - $clog2(MS_PER_S) + 1;
	localparam longint MS_RECIP = ((longint'(1) << RECIP_SH) + MS_PER_S - 1) / MS_PER_S;
	localparam int PROD_W = REM_W + RECIP_W;

	typedef logic signed [STATE_WIDTH-1:0] word_t;
	typedef logic signed [CFG_W-1:0] cfg_word_t;

	localparam longint FX_ONE = longint'(1) << FRAC_BITS;

	localparam word_t SAT_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
	localparam word_t SAT_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

	localparam word_t K_QUAD = word_t'((4 * FX_ONE + 50) / 100);
	localparam word_t K_LIN = word_t'(5 * FX_ONE);
	localparam word_t K_140 = word_t'(140 * FX_ONE);
	localparam word_t K_HALF = word_t'((FX_ONE + 1) / 2);
	localparam word_t K_SYN_DECAY = word_t'((8 * FX_ONE + 5) / 10);
	localparam word_t K_DEND_DECAY = word_t'((95 * FX_ONE + 50) / 100);
	localparam word_t K_DRIFT_DOWN = word_t'((2 * FX_ONE + 50) / 100);
	localparam word_t K_DRIFT_UP = word_t'((3 * FX_ONE + 50) / 100);
	localparam word_t K_RELAX = word_t'((FX_ONE + 500) / 1000);
	localparam word_t K_THR_MIN = word_t'(22 * FX_ONE);
	localparam word_t K_THR_MAX = word_t'(32 * FX_ONE);
	localparam word_t K_THR_REST = word_t'(30 * FX_ONE);
	localparam word_t V_RESET = word_t'(-(65 * FX_ONE));
	localparam word_t U_RESET = word_t'(-(13 * FX_ONE));

	localparam cfg_word_t A_RESET = cfg_word_t'((2 * FX_ONE + 50) / 100);
	localparam cfg_word_t B_RESET = cfg_word_t'((2 * FX_ONE + 5) / 10);
	localparam cfg_word_t C_RESET = cfg_word_t'(-(65 * FX_ONE));
	localparam cfg_word_t D_RESET = cfg_word_t'(8 * FX_ONE);
	localparam cfg_word_t BIAS_RESET = cfg_word_t'(3 * FX_ONE);

	localparam logic [CFG_W-1:0] RATE_LOW = CFG_W'(FX_ONE / 2);
	localparam logic [CFG_W-1:0] RATE_HIGH = CFG_W'(8 * FX_ONE);

	typedef enum logic [1:0] {
		OP_TICK,
		OP_DRIFT,
		OP_INIT
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RECOVERY_RATE,
		CFG_RECOVERY_SENS,
		CFG_RESET_POT,
		CFG_RESET_INC,
		CFG_BIAS
	} cfg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TICK_ADD,
		ST_ITOT_SD,
		ST_ITOT_BIAS,
		ST_ITOT_NOISE,
		ST_HS_SQ1,
		ST_HS_SQ2,
		ST_HS_LIN,
		ST_HS_K140,
		ST_HS_SUBU,
		ST_HS_ADDI,
		ST_HS_HALF,
		ST_REC_BV,
		ST_REC_AF,
		ST_SPIKE,
		ST_DECAY_SYN,
		ST_DECAY_DEND,
		ST_DRIFT_DIV,
		ST_DRIFT_LO,
		ST_DRIFT_HI,
		ST_DRIFT_DIFF,
		ST_DRIFT_SCALE,
		ST_DRIFT_MID,
		ST_INIT_V,
		ST_INIT_U,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [CFG_W-1:0] synaptic_add;
		logic signed [CFG_W-1:0] dendritic_add;
		logic signed [CFG_W-1:0] noise_current;
		logic [CFG_W-1:0] firing_rate;
		logic [MS_W-1:0] drift_ms;
	} req_t;

	typedef struct packed {
		logic fired;
		logic signed [STATE_WIDTH-1:0] membrane_potential;
		logic signed [STATE_WIDTH-1:0] recovery_value;
		logic signed [STATE_WIDTH-1:0] threshold_level;
	} rsp_t;

	function automatic word_t sat_add(word_t a, word_t b);
		logic [STATE_WIDTH:0] s;
		s = {a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b};
		if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
			return s[STATE_WIDTH] ? SAT_MIN : SAT_MAX;
		end
		return s[STATE_WIDTH-1:0];
	endfunction

	function automatic word_t sat_sub(word_t a, word_t b);
		logic [STATE_WIDTH:0] s;
		s = {a[STATE_WIDTH-1], a} - {b[STATE_WIDTH-1], b};
		if (s[STATE_WIDTH] != s[STATE_WIDTH-1]) begin
			return s[STATE_WIDTH] ? SAT_MIN : SAT_MAX;
		end
		return s[STATE_WIDTH-1:0];
	endfunction

	function automatic word_t sext32(logic [CFG_W-1:0] x);
		return {{(STATE_WIDTH-CFG_W){x[CFG_W-1]}}, x};
	endfunction

endpackage

// ----- rtl/core/izh_mul.sv -----
// Shared fixed-point multiplier: four half-width partial products, round and saturate.
module izh_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input izh_pkg::word_t op_a,
	input izh_pkg::word_t op_b,
	output logic done,
	output izh_pkg::word_t prod
);
	import izh_pkg::*;

	localparam int PART_W = STATE_WIDTH / 2;
	localparam int ACC_W = 2 * STATE_WIDTH;
	localparam int Q_W = ACC_W - FRAC_BITS;

	typedef logic [STATE_WIDTH-1:0] mag_t;

	logic run_q, fin_q, done_q, neg_q;
	logic [1:0] step_q;
	mag_t ma_q, mb_q;
	logic [ACC_W-1:0] acc_q;
	word_t prod_q;
	logic [PART_W-1:0] pa, pb;
	logic [2*PART_W-1:0] pp;
	logic [ACC_W-1:0] pp_sh;
	logic [Q_W-1:0] q_full;
	mag_t lim, q_sat;

	function automatic mag_t magnitude(word_t x);
		return x[STATE_WIDTH-1] ? mag_t'(mag_t'(0) - mag_t'(x)) : mag_t'(x);
	endfunction

	always_comb begin
		pa = step_q[1] ? ma_q[STATE_WIDTH-1:PART_W] : ma_q[PART_W-1:0];
		pb = step_q[0] ? mb_q[STATE_WIDTH-1:PART_W] : mb_q[PART_W-1:0];
		pp = pa * pb;
		case (step_q)
			2'd0: pp_sh = ACC_W'(pp);
			2'd1, 2'd2: pp_sh = ACC_W'(pp) << PART_W;
			default: pp_sh = ACC_W'(pp) << (2 * PART_W);
		endcase
		q_full = acc_q[ACC_W-1:FRAC_BITS];
		lim = neg_q ? mag_t'(SAT_MAX) + mag_t'(1) : mag_t'(SAT_MAX);
		q_sat = (q_full > Q_W'(lim)) ? lim : q_full[STATE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= run_q && (step_q == 2'd3);
			done_q <= fin_q;
			if (start) begin
				run_q <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// accumulator starts at half an LSB of the result for round-to-nearest
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= op_a[STATE_WIDTH-1] ^ op_b[STATE_WIDTH-1];
			ma_q <= magnitude(op_a);
			mb_q <= magnitude(op_b);
			acc_q <= ACC_W'(1) << (FRAC_BITS - 1);
		end else if (run_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (fin_q) begin
			prod_q <= neg_q ? word_t'(mag_t'(0) - q_sat) : word_t'(q_sat);
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ----- rtl/core/izhikevich_neuron_step.sv -----
// Izhikevich neuron core: sequencer, state, configuration and result register.
//
// One Izhikevich neuron in Q23.24 fixed point. Every product goes through one
// shared multiplier that builds a 48x48 product from four 24x24 partial products.
// A tick (opcode 0) needs twelve products counting both half-steps, recovery and
// current decay. Threshold drift (opcode 1) first finishes the division of the
// elapsed time by 1000 with a reciprocal multiply. Reinitialize is opcode 2, and
// the unused opcode goes straight to the result. The core takes one request at
// a time and is ready again in the cycle after its result is loaded into the
// output register, even while that result waits to be taken.
module izhikevich_neuron_step (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input izh_pkg::req_t req_data,
	output logic rsp_valid,
	input logic rsp_ready,
	output izh_pkg::rsp_t rsp_data,
	input logic wr_en,
	input logic [izh_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [izh_pkg::CFG_W-1:0] wr_data
);
	import izh_pkg::*;

	state_t state_q, state_d;

	cfg_word_t a_q, b_q, c_q, d_q, bias_q;
	word_t v_q, u_q, syn_q, dend_q, thr_q;
	logic fired_q, hs_q, wait_q, rsp_valid_q;

	req_t req_q;
	rsp_t rsp_q;
	word_t vt_q, f_q, itot_q;
	logic [DIV_W-1:0] n_q;
	logic [REM_W-1:0] rem_q;

	logic accept, load_rsp, mul_op, mul_start, mul_done;
	word_t mul_a, mul_b, prod, delta, t_sum;
	logic [PROD_W-1:0] frac_prod;

	izh_mul u_mul (
		.clk (clk),
		.arst_n (arst_n),
		.start (mul_start),
		.op_a (mul_a),
		.op_b (mul_b),
		.done (mul_done),
		.prod (prod)
	);

	assign accept = req_valid && req_ready;
	assign load_rsp = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign mul_start = mul_op && !wait_q;
	assign delta = word_t'({{(STATE_WIDTH-DIV_W){1'b0}}, n_q});
	assign frac_prod = PROD_W'(rem_q) * PROD_W'(MS_RECIP);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode_t'(req_data.opcode))
						OP_TICK: state_d = ST_TICK_ADD;
						OP_DRIFT: state_d = ST_DRIFT_DIV;
						OP_INIT: state_d = ST_INIT_V;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_TICK_ADD: state_d = ST_ITOT_SD;
			ST_ITOT_SD: state_d = ST_ITOT_BIAS;
			ST_ITOT_BIAS: state_d = ST_ITOT_NOISE;
			ST_ITOT_NOISE: state_d = ST_HS_SQ1;
			ST_HS_SQ1: if (mul_done) state_d = ST_HS_SQ2;
			ST_HS_SQ2: if (mul_done) state_d = ST_HS_LIN;
			ST_HS_LIN: if (mul_done) state_d = ST_HS_K140;
			ST_HS_K140: state_d = ST_HS_SUBU;
			ST_HS_SUBU: state_d = ST_HS_ADDI;
			ST_HS_ADDI: state_d = ST_HS_HALF;
			ST_HS_HALF: begin
				if (mul_done) begin
					state_d = hs_q ? ST_REC_BV : ST_HS_SQ1;
				end
			end
			ST_REC_BV: if (mul_done) state_d = ST_REC_AF;
			ST_REC_AF: if (mul_done) state_d = ST_SPIKE;
			ST_SPIKE: state_d = ST_DECAY_SYN;
			ST_DECAY_SYN: if (mul_done) state_d = ST_DECAY_DEND;
			ST_DECAY_DEND: if (mul_done) state_d = ST_DONE;
			ST_DRIFT_DIV: begin
				if (req_q.firing_rate < RATE_LOW) begin
					state_d = ST_DRIFT_LO;
				end else if (req_q.firing_rate > RATE_HIGH) begin
					state_d = ST_DRIFT_HI;
				end else begin
					state_d = ST_DRIFT_DIFF;
				end
			end
			ST_DRIFT_LO: if (mul_done) state_d = ST_DONE;
			ST_DRIFT_HI: if (mul_done) state_d = ST_DONE;
			ST_DRIFT_DIFF: state_d = ST_DRIFT_SCALE;
			ST_DRIFT_SCALE: if (mul_done) state_d = ST_DRIFT_MID;
			ST_DRIFT_MID: if (mul_done) state_d = ST_DONE;
			ST_INIT_V: state_d = ST_INIT_U;
			ST_INIT_U: if (mul_done) state_d = ST_DONE;
			ST_DONE: if (load_rsp) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		mul_op = 1'b1;
		mul_a = f_q;
		mul_b = vt_q;
		case (state_q)
			ST_HS_SQ1: mul_a = K_QUAD;
			ST_HS_SQ2: mul_a = f_q;
			ST_HS_LIN: mul_a = K_LIN;
			ST_HS_HALF: begin
				mul_a = K_HALF;
				mul_b = f_q;
			end
			ST_REC_BV: mul_a = sext32(b_q);
			ST_REC_AF: begin
				mul_a = sext32(a_q);
				mul_b = f_q;
			end
			ST_DECAY_SYN: begin
				mul_a = syn_q;
				mul_b = K_SYN_DECAY;
			end
			ST_DECAY_DEND: begin
				mul_a = dend_q;
				mul_b = K_DEND_DECAY;
			end
			ST_DRIFT_LO: begin
				mul_a = K_DRIFT_DOWN;
				mul_b = delta;
			end
			ST_DRIFT_HI: begin
				mul_a = K_DRIFT_UP;
				mul_b = delta;
			end
			ST_DRIFT_SCALE: mul_b = K_RELAX;
			ST_DRIFT_MID: mul_b = delta;
			ST_INIT_U: begin
				mul_a = sext32(b_q);
				mul_b = v_q;
			end
			default: mul_op = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			a_q <= A_RESET;
			b_q <= B_RESET;
			c_q <= C_RESET;
			d_q <= D_RESET;
			bias_q <= BIAS_RESET;
			v_q <= V_RESET;
			u_q <= U_RESET;
			syn_q <= '0;
			dend_q <= '0;
			thr_q <= K_THR_REST;
			fired_q <= 1'b0;
			hs_q <= 1'b0;
			wait_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (cfg_index_t'(wr_index))
					CFG_RECOVERY_RATE: a_q <= wr_data;
					CFG_RECOVERY_SENS: b_q <= wr_data;
					CFG_RESET_POT: c_q <= wr_data;
					CFG_RESET_INC: d_q <= wr_data;
					CFG_BIAS: bias_q <= wr_data;
					default: ;
				endcase
			end
			if (mul_start) begin
				wait_q <= 1'b1;
			end else if (mul_done) begin
				wait_q <= 1'b0;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				fired_q <= 1'b0;
			end
			case (state_q)
				ST_TICK_ADD: begin
					syn_q <= sat_add(syn_q, sext32(req_q.synaptic_add));
					dend_q <= sat_add(dend_q, sext32(req_q.dendritic_add));
					hs_q <= 1'b0;
				end
				ST_HS_HALF: if (mul_done) hs_q <= 1'b1;
				ST_SPIKE: begin
					if (vt_q >= thr_q) begin
						v_q <= sext32(c_q);
						u_q <= sat_add(f_q, sext32(d_q));
						fired_q <= 1'b1;
					end else begin
						v_q <= vt_q;
						u_q <= f_q;
					end
				end
				ST_DECAY_SYN: if (mul_done) syn_q <= prod;
				ST_DECAY_DEND: if (mul_done) dend_q <= prod;
				ST_DRIFT_LO: begin
					if (mul_done) begin
						thr_q <= (t_sum < K_THR_MIN) ? K_THR_MIN : t_sum;
					end
				end
				ST_DRIFT_HI: begin
					if (mul_done) begin
						thr_q <= (t_sum > K_THR_MAX) ? K_THR_MAX : t_sum;
					end
				end
				ST_DRIFT_MID: if (mul_done) thr_q <= t_sum;
				ST_INIT_V: begin
					v_q <= sext32(c_q);
					syn_q <= '0;
					dend_q <= '0;
					thr_q <= K_THR_REST;
				end
				ST_INIT_U: if (mul_done) u_q <= prod;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (state_q == ST_DRIFT_LO) begin
			t_sum = sat_sub(thr_q, prod);
		end else begin
			t_sum = sat_add(thr_q, prod);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_data;
			n_q <= DIV_W'(req_data.drift_ms) * DIV_W'(MS_FX_INT);
			rem_q <= REM_W'(req_data.drift_ms) * REM_W'(MS_FX_REM) + REM_W'(MS_HALF);
		end
		if (load_rsp) begin
			rsp_q <= {fired_q, v_q, u_q, thr_q};
		end
		case (state_q)
			ST_TICK_ADD: vt_q <= v_q;
			ST_ITOT_SD: itot_q <= sat_add(syn_q, dend_q);
			ST_ITOT_BIAS: itot_q <= sat_add(itot_q, sext32(bias_q));
			ST_ITOT_NOISE: itot_q <= sat_add(itot_q, sext32(req_q.noise_current));
			ST_HS_SQ1: if (mul_done) f_q <= prod;
			ST_HS_SQ2: if (mul_done) f_q <= prod;
			ST_HS_LIN: if (mul_done) f_q <= sat_add(f_q, prod);
			ST_HS_K140: f_q <= sat_add(f_q, K_140);
			ST_HS_SUBU: f_q <= sat_sub(f_q, u_q);
			ST_HS_ADDI: f_q <= sat_add(f_q, itot_q);
			ST_HS_HALF: if (mul_done) vt_q <= sat_add(vt_q, prod);
			ST_REC_BV: if (mul_done) f_q <= sat_sub(prod, u_q);
			ST_REC_AF: if (mul_done) f_q <= sat_add(u_q, prod);
			ST_DRIFT_DIV: n_q <= n_q + DIV_W'(frac_prod >> RECIP_SH);
			ST_DRIFT_DIFF: f_q <= sat_sub(K_THR_REST, thr_q);
			ST_DRIFT_SCALE: if (mul_done) f_q <= prod;
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

`ifndef SYNTH
	a_mul_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> wait_q)
		else $error("multiplier result with no product outstanding");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !wait_q && !mul_done)
		else $error("request taken while a product is outstanding");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finishing step");

	a_drift_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRIFT_LO) && mul_done |=> thr_q >= K_THR_MIN)
		else $error("downward drift left threshold below its floor");
`endif

endmodule

// ----- verif/izh_step_checker.sv -----
// Request/result checker for the neuron step: predicts each result and compares it.
`timescale 1ns / 100ps
module izh_step_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input izh_pkg::req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input izh_pkg::rsp_t rsp_data,
	input logic wr_en,
	input logic [izh_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [izh_pkg::CFG_W-1:0] wr_data,
	output int mismatches,
	output int outstanding,
	output int spikes
);
	import izh_pkg::*;

	localparam longint ONE = longint'(1) << 24;
	localparam longint W_MAX = (longint'(1) << 47) - 1;
	localparam longint W_MIN = -(longint'(1) << 47);

	localparam word_t C_QUAD = word_t'((4 * ONE + 50) / 100);
	localparam word_t C_LIN = word_t'(5 * ONE);
	localparam word_t C_140 = word_t'(140 * ONE);
	localparam word_t C_HALF = word_t'((ONE + 1) / 2);
	localparam word_t C_SYN_FADE = word_t'((8 * ONE + 5) / 10);
	localparam word_t C_DEND_FADE = word_t'((95 * ONE + 50) / 100);
	localparam word_t C_THR_DOWN = word_t'((2 * ONE + 50) / 100);
	localparam word_t C_THR_UP = word_t'((3 * ONE + 50) / 100);
	localparam word_t C_THR_PULL = word_t'((ONE + 500) / 1000);
	localparam word_t C_THR_LO = word_t'(22 * ONE);
	localparam word_t C_THR_HI = word_t'(32 * ONE);
	localparam word_t C_THR_REST = word_t'(30 * ONE);
	localparam word_t C_V_REST = word_t'(-(65 * ONE));
	localparam word_t C_U_REST = word_t'(-(13 * ONE));
	localparam logic [31:0] SLOW_RATE = 32'h0080_0000;
	localparam logic [31:0] FAST_RATE = 32'h0800_0000;

	word_t par_a, par_b, par_c, par_d, par_bias;
	word_t v_now, u_now, i_syn, i_dend, v_thr;
	rsp_t expected_states[$];
	rsp_t want;
	int errs, spike_cnt;

	function automatic word_t widen(logic signed [31:0] x);
		return x;
	endfunction

	function automatic word_t clip(longint s);
		if (s > W_MAX) return word_t'(W_MAX);
		if (s < W_MIN) return word_t'(W_MIN);
		return word_t'(s);
	endfunction

	function automatic word_t sat_plus(word_t a, word_t b);
		return clip(longint'(a) + longint'(b));
	endfunction

	function automatic word_t sat_minus(word_t a, word_t b);
		return clip(longint'(a) - longint'(b));
	endfunction

	function automatic word_t fx_mul(word_t a, word_t b);
		logic neg;
		logic [47:0] ma, mb, r;
		logic [95:0] p;
		logic [71:0] q, lim;
		neg = a[47] ^ b[47];
		ma = a[47] ? -a : a;
		mb = b[47] ? -b : b;
		p = {48'd0, ma} * {48'd0, mb};
		q = 72'((p + 96'h80_0000) >> 24);
		lim = neg ? 72'h8000_0000_0000 : 72'h7FFF_FFFF_FFFF;
		if (q > lim) q = lim;
		r = q[47:0];
		if (neg) r = -r;
		return r;
	endfunction

	function automatic word_t half_update(word_t v, word_t u, word_t i_in);
		word_t f;
		f = fx_mul(fx_mul(C_QUAD, v), v);
		f = sat_plus(f, fx_mul(C_LIN, v));
		f = sat_plus(f, C_140);
		f = sat_minus(f, u);
		f = sat_plus(f, i_in);
		return sat_plus(v, fx_mul(C_HALF, f));
	endfunction

	function automatic rsp_t neuron_advance(req_t r);
		rsp_t o;
		word_t i_tot, v, u, t, delta;
		logic [63:0] scaled_ms;
		o = '0;
		case (r.opcode)
			OP_TICK: begin
				i_syn = sat_plus(i_syn, widen(r.synaptic_add));
				i_dend = sat_plus(i_dend, widen(r.dendritic_add));
				i_tot = sat_plus(sat_plus(sat_plus(i_syn, i_dend), par_bias),
					widen(r.noise_current));
				v = half_update(v_now, u_now, i_tot);
				v = half_update(v, u_now, i_tot);
				u = sat_plus(u_now, fx_mul(par_a, sat_minus(fx_mul(par_b, v), u_now)));
				if (v >= v_thr) begin
					v = par_c;
					u = sat_plus(u, par_d);
					o.fired = 1'b1;
				end
				v_now = v;
				u_now = u;
				i_syn = fx_mul(i_syn, C_SYN_FADE);
				i_dend = fx_mul(i_dend, C_DEND_FADE);
			end
			OP_DRIFT: begin
				scaled_ms = ({48'd0, r.drift_ms} << 24) + 64'd500;
				delta = word_t'(scaled_ms / 64'd1000);
				t = v_thr;
				if (r.firing_rate < SLOW_RATE) begin
					t = sat_minus(t, fx_mul(C_THR_DOWN, delta));
					if (t < C_THR_LO) t = C_THR_LO;
				end else if (r.firing_rate > FAST_RATE) begin
					t = sat_plus(t, fx_mul(C_THR_UP, delta));
					if (t > C_THR_HI) t = C_THR_HI;
				end else begin
					t = sat_plus(t, fx_mul(fx_mul(sat_minus(C_THR_REST, t), C_THR_PULL), delta));
				end
				v_thr = t;
			end
			OP_INIT: begin
				v_now = par_c;
				u_now = fx_mul(par_b, v_now);
				i_syn = '0;
				i_dend = '0;
				v_thr = C_THR_REST;
			end
			default: begin
			end
		endcase
		o.membrane_potential = v_now;
		o.recovery_value = u_now;
		o.threshold_level = v_thr;
		return o;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] exp_v,
		input logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_a = word_t'((2 * ONE + 50) / 100);
			par_b = word_t'((2 * ONE + 5) / 10);
			par_c = C_V_REST;
			par_d = word_t'(8 * ONE);
			par_bias = word_t'(3 * ONE);
			v_now = C_V_REST;
			u_now = C_U_REST;
			i_syn = '0;
			i_dend = '0;
			v_thr = C_THR_REST;
			expected_states.delete();
			errs = 0;
			spike_cnt = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_RECOVERY_RATE: par_a = widen(wr_data);
					CFG_RECOVERY_SENS: par_b = widen(wr_data);
					CFG_RESET_POT: par_c = widen(wr_data);
					CFG_RESET_INC: par_d = widen(wr_data);
					CFG_BIAS: par_bias = widen(wr_data);
					default: begin
					end
				endcase
			end
			if (req_valid && req_ready) expected_states.push_back(neuron_advance(req_data));
			if (rsp_valid && rsp_ready) begin
				if (expected_states.size() == 0) begin
					$error("result with no request outstanding");
					errs++;
				end else begin
					want = expected_states.pop_front();
					compare_field("fired", want.fired, rsp_data.fired);
					compare_field("membrane_potential", want.membrane_potential,
						rsp_data.membrane_potential);
					compare_field("recovery_value", want.recovery_value, rsp_data.recovery_value);
					compare_field("threshold_level", want.threshold_level,
						rsp_data.threshold_level);
					if (rsp_data.fired === 1'b1) spike_cnt++;
				end
			end
		end
		mismatches <= errs;
		outstanding <= expected_states.size();
		spikes <= spike_cnt;
	end

endmodule

// ----- verif/tb_izhikevich_neuron_step.sv -----
// Top-level testbench for the neuron step: stimulus, parameter phases and verdict.
`timescale 1ns / 100ps
module tb_izhikevich_neuron_step;
	import izh_pkg::*;

	localparam int PHASE_ITEMS = 125;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 100;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [31:0] SLOW_RATE = 32'h0080_0000;
	localparam logic [31:0] FAST_RATE = 32'h0800_0000;
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;
	localparam logic [31:0] Q_ONE = 32'h0100_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_data;
	logic wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	int mismatches, outstanding, spikes;
	int op_count[4] = '{0, 0, 0, 0};
	int sets_loaded = 0;
	int idle_cycles = 0;
	bit long_hold = 0;
	bit quiet = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	izhikevich_neuron_step i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	izh_step_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.spikes(spikes)
	);

	function automatic req_t mk_req(logic [1:0] op, logic [31:0] syn, logic [31:0] dend,
		logic [31:0] noise, logic [31:0] rate, logic [15:0] ms);
		req_t r;
		r.opcode = op;
		r.synaptic_add = syn;
		r.dendritic_add = dend;
		r.noise_current = noise;
		r.firing_rate = rate;
		r.drift_ms = ms;
		return r;
	endfunction

	function automatic logic [31:0] mild(int span);
		int lim;
		lim = span << 24;
		return 32'($urandom_range(0, 2 * lim)) - 32'(lim);
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, SLOW_RATE - 1);
			1: return SLOW_RATE - 1;
			2: return SLOW_RATE;
			3: return $urandom_range(SLOW_RATE, FAST_RATE);
			4: return FAST_RATE;
			5: return FAST_RATE + 1;
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t random_req();
		req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r = mk_req(OP_TICK, $urandom, $urandom, $urandom, $urandom, 16'($urandom));
		if (roll < 55) begin
			r.synaptic_add = mild(20);
			r.dendritic_add = mild(10);
			r.noise_current = mild(5);
		end else if (roll < 65) begin
			r.opcode = OP_TICK;
		end else if (roll < 80) begin
			r.opcode = OP_DRIFT;
			r.firing_rate = pick_rate();
			r.drift_ms = $urandom_range(0, 1) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
		end else if (roll < 87) begin
			r.opcode = OP_INIT;
		end else if (roll < 90) begin
			r.opcode = OP_UNUSED;
		end else begin
			r.synaptic_add = '0;
			r.dendritic_add = '0;
			r.noise_current = mild(5);
		end
		return r;
	endfunction

	task automatic send(input req_t r);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		op_count[r.opcode]++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_params(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d, input logic [31:0] bias);
		wr_en <= 1'b1;
		wr_index <= CFG_RECOVERY_RATE;
		wr_data <= a;
		@(posedge clk);
		wr_index <= CFG_RECOVERY_SENS;
		wr_data <= b;
		@(posedge clk);
		wr_index <= CFG_RESET_POT;
		wr_data <= c;
		@(posedge clk);
		wr_index <= CFG_RESET_INC;
		wr_data <= d;
		@(posedge clk);
		wr_index <= CFG_BIAS;
		wr_data <= bias;
		@(posedge clk);
		wr_en <= 1'b0;
		sets_loaded++;
	endtask

	// result side: short random stalls, plus one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 0;
			end
			stall = quiet ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || wr_en || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk_req(OP_TICK, '0, '0, '0, '0, '0));
		send(mk_req(OP_TICK, 5 * Q_ONE, 2 * Q_ONE, '0, '0, '0));
		send(mk_req(OP_TICK, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 16'hFFFF));
		send(mk_req(OP_TICK, Q_MIN, Q_MIN, Q_MIN, '0, '0));
		send(mk_req(OP_TICK, '0, '0, '0, '0, '0));
		send(mk_req(OP_INIT, '0, '0, '0, '0, '0));
		send(mk_req(OP_DRIFT, '0, '0, '0, '0, 16'hFFFF));
		send(mk_req(OP_DRIFT, '0, '0, '0, 32'hFFFF_FFFF, 16'hFFFF));
		send(mk_req(OP_DRIFT, '0, '0, '0, SLOW_RATE - 1, 16'd1000));
		send(mk_req(OP_DRIFT, '0, '0, '0, SLOW_RATE, 16'd499));
		send(mk_req(OP_DRIFT, '0, '0, '0, FAST_RATE, 16'd500));
		send(mk_req(OP_DRIFT, '0, '0, '0, FAST_RATE + 1, 16'd1));
		send(mk_req(OP_DRIFT, '0, '0, '0, '0, '0));
		send(mk_req(OP_UNUSED, Q_MAX, Q_MAX, Q_MAX, 32'hFFFF_FFFF, 16'hFFFF));
		send(mk_req(OP_TICK, 10 * Q_ONE, '0, '0, '0, '0));
		repeat (5) send(mk_req(OP_TICK, '0, '0, '0, '0, '0));
		send(mk_req(OP_INIT, '0, '0, '0, '0, '0));
		send(mk_req(OP_TICK, '0, '0, Q_MIN, '0, '0));
		send(mk_req(OP_UNUSED, '0, '0, '0, '0, '0));
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: load_params(32'd335544, 32'd3355443, 32'hBF00_0000, 8 * Q_ONE, 3 * Q_ONE);
				1: load_params(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
				2: load_params(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
				3: load_params(32'd1677722, 32'd3355443, 32'hBF00_0000, 2 * Q_ONE, 10 * Q_ONE);
				4: load_params(32'd335544, 32'd3355443, 32'hCE00_0000, 2 * Q_ONE, 5 * Q_ONE);
				5: load_params($urandom, $urandom, $urandom, $urandom, $urandom);
				6: load_params($urandom_range(167772, 1677722), $urandom_range(3355443, 4194304),
					-$urandom_range(838860800, 1090519040), $urandom_range(838861, 134217728),
					$urandom_range(0, 251658240));
				default: load_params('0, '0, '0, '0, '0);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == 80) quiet = 1;
				if (i == 110) quiet = 0;
				if (p == 2 && i == 10) long_hold = 1;
				if (i == 60) drain();
				send(random_req());
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests: %0d ticks, %0d drifts, %0d re-inits, %0d unused opcode",
			op_count[0] + op_count[1] + op_count[2] + op_count[3],
			op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("%0d parameter sets loaded, %0d spikes checked, %0d mismatches",
			sets_loaded, spikes, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
